// ===== sv/gzhp_pkg.sv =====
// ----------------------------------------------------------------------------
// gzhp_pkg
// Types and constants shared by the gzip member header parser modules.
// ----------------------------------------------------------------------------
package gzhp_pkg;

  typedef enum logic [3:0] {
    PH_MAGIC0  = 4'd0,
    PH_MAGIC1  = 4'd1,
    PH_METHOD  = 4'd2,
    PH_FLAGS   = 4'd3,
    PH_SKIP    = 4'd4,
    PH_XLO     = 4'd5,
    PH_XHI     = 4'd6,
    PH_XDATA   = 4'd7,
    PH_NAME    = 4'd8,
    PH_COMMENT = 4'd9,
    PH_HCRC    = 4'd10,
    PH_PAYLOAD = 4'd11,
    PH_STOPPED = 4'd12
  } phase_t;

  typedef enum logic [3:0] {
    ST_HDR     = 4'd0,
    ST_DONE    = 4'd1,
    ST_PAYLOAD = 4'd2,
    ST_NOTGZ   = 4'd3,
    ST_METHOD  = 4'd4,
    ST_GARBAGE = 4'd5,
    ST_TRUNC   = 4'd6,
    ST_STOPPED = 4'd7,
    ST_END     = 4'd8
  } status_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  flags;
    logic [15:0] skip_left;
    logic        member_seen;
  } parse_state_t;

  localparam logic [7:0] MAGIC0_BYTE   = 8'h1F;
  localparam logic [7:0] MAGIC1_BYTE   = 8'h8B;
  localparam logic [7:0] MAGIC1_OLD    = 8'h9E;
  localparam logic [7:0] METHOD_DEFL   = 8'h08;
  localparam int unsigned FLG_FHCRC    = 1;
  localparam int unsigned FLG_FEXTRA   = 2;
  localparam int unsigned FLG_FNAME    = 3;
  localparam int unsigned FLG_FCOMMENT = 4;
  localparam logic [15:0] FIXED_SKIP   = 16'd6;
  localparam logic [15:0] HCRC_LEN     = 16'd2;

endpackage

// ===== sv/gzhp_step.sv =====
// ----------------------------------------------------------------------------
// gzhp_step
// Next-state and status logic for one stream byte of the header walk.
// ----------------------------------------------------------------------------
module gzhp_step
  import gzhp_pkg::*;
(
  input  parse_state_t cur,
  input  logic [7:0]   in_byte,
  input  logic         in_end,
  input  logic         in_restart,
  output parse_state_t nxt,
  output status_t      status,
  output logic [7:0]   payload
);

  phase_t       ph0;
  parse_state_t s;
  logic [15:0]  skip_dec;

  always_comb begin
    ph0      = in_restart ? PH_MAGIC0 : cur.phase;
    s        = cur;
    s.phase  = ph0;
    status   = ST_HDR;
    payload  = 8'd0;
    skip_dec = (cur.skip_left != 16'd0) ? cur.skip_left - 16'd1 : 16'd0;

    if (ph0 >= PH_STOPPED) begin
      s.phase = PH_STOPPED;
      status  = ST_STOPPED;
    end else if (in_end) begin
      status  = (ph0 == PH_MAGIC0 || ph0 == PH_PAYLOAD) ? ST_END : ST_TRUNC;
      s.phase = PH_STOPPED;
    end else if (ph0 == PH_PAYLOAD) begin
      status  = ST_PAYLOAD;
      payload = in_byte;
    end else begin
      case (ph0)
        PH_MAGIC0: begin
          if (in_byte != MAGIC0_BYTE) begin
            status  = cur.member_seen ? ST_GARBAGE : ST_NOTGZ;
            s.phase = PH_STOPPED;
          end else begin
            s.member_seen = 1'b1;
            s.flags       = 8'd0;
            s.phase       = PH_MAGIC1;
          end
        end
        PH_MAGIC1: begin
          if (!(in_byte inside {MAGIC1_BYTE, MAGIC1_OLD})) begin
            status  = ST_NOTGZ;
            s.phase = PH_STOPPED;
          end else begin
            s.phase = PH_METHOD;
          end
        end
        PH_METHOD: begin
          if (in_byte != METHOD_DEFL) begin
            status  = ST_METHOD;
            s.phase = PH_STOPPED;
          end else begin
            s.phase = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          s.flags     = in_byte;
          s.skip_left = FIXED_SKIP;
          s.phase     = PH_SKIP;
        end
        PH_SKIP: begin
          s.skip_left = skip_dec;
          if (skip_dec == 16'd0) s.phase = PH_XLO;
        end
        PH_XLO: begin
          s.skip_left = {8'd0, in_byte};
          s.phase     = PH_XHI;
        end
        PH_XHI: begin
          s.skip_left = {in_byte, cur.skip_left[7:0]};
          s.phase     = PH_XDATA;
        end
        PH_XDATA: s.skip_left = skip_dec;
        PH_NAME: begin
          if (in_byte == 8'd0) s.phase = PH_COMMENT;
        end
        PH_COMMENT: begin
          if (in_byte == 8'd0) begin
            s.phase     = PH_HCRC;
            s.skip_left = cur.flags[FLG_FHCRC] ? HCRC_LEN : 16'd0;
          end
        end
        PH_HCRC: s.skip_left = skip_dec;
        default: s.phase = PH_STOPPED;
      endcase

      // pass over optional parts that are absent or already used up
      if ((s.phase == PH_XLO && !s.flags[FLG_FEXTRA]) ||
          (s.phase == PH_XDATA && s.skip_left == 16'd0)) begin
        s.phase = PH_NAME;
      end
      if (s.phase == PH_NAME && !s.flags[FLG_FNAME]) s.phase = PH_COMMENT;
      if (s.phase == PH_COMMENT && !s.flags[FLG_FCOMMENT]) begin
        s.phase     = PH_HCRC;
        s.skip_left = s.flags[FLG_FHCRC] ? HCRC_LEN : 16'd0;
      end
      if (s.phase == PH_HCRC && s.skip_left == 16'd0) s.phase = PH_PAYLOAD;

      if (status == ST_HDR && s.phase == PH_PAYLOAD) status = ST_DONE;
    end
    nxt = s;
  end

endmodule

// ===== sv/gzip_member_header_parser.sv =====
// ----------------------------------------------------------------------------
// gzip_member_header_parser
// Walks gzip member headers one byte per item and tags every byte.
// ----------------------------------------------------------------------------
// Usage:
//   in_ channel: one stream byte per item, with end_mark (input has ended)
//   and restart (go back to the first magic byte for the next member).
//   out_ channel: one item per input item: status, payload_byte (the byte
//   itself when status is payload, else zero) and header_flags (the flag
//   byte of the current header).
//   An accepted item's result is registered and is on out_ in the cycle
//   after it is accepted. Throughput is one item per cycle while out_ is not
//   stalled, set by the single state update and the one result register.
//   in_ready stays high while the result register is empty or being taken,
//   so a stalled receiver holds at most one result and then back-pressures
//   the input.
//   After reset the parser expects a first magic byte, the flags read zero
//   and no member has been seen yet. Once stopped, every item without
//   restart reports stopped.
// ----------------------------------------------------------------------------
module gzip_member_header_parser
  import gzhp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_mark,
  input  logic       in_restart,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_status,
  output logic [7:0] out_payload_byte,
  output logic [7:0] out_header_flags
);

  parse_state_t state_r;
  parse_state_t state_nxt;
  status_t      status_nxt;
  status_t      status_r;
  logic [7:0]   payload_nxt;
  logic [7:0]   payload_r;
  logic [7:0]   flags_r;
  logic         out_valid_r;
  logic         accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  gzhp_step u_step (
    .cur        (state_r),
    .in_byte    (in_data_byte),
    .in_end     (in_end_mark),
    .in_restart (in_restart),
    .nxt        (state_nxt),
    .status     (status_nxt),
    .payload    (payload_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= PH_MAGIC0;
      state_r.flags       <= 8'd0;
      state_r.skip_left   <= 16'd0;
      state_r.member_seen <= 1'b0;
      out_valid_r         <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      payload_r <= payload_nxt;
      flags_r   <= state_nxt.flags;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_payload_byte = payload_r;
  assign out_header_flags = flags_r;

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != ST_PAYLOAD |-> payload_r == 8'd0)
    else $error("payload byte set on a non-payload item");

  a_done_enters_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_DONE |-> state_r.phase == PH_PAYLOAD)
    else $error("header done without entering payload");

  a_stopped_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    accept && state_r.phase == PH_STOPPED && !in_restart
    |=> status_r == ST_STOPPED && state_r.phase == PH_STOPPED)
    else $error("stopped parser did not stay stopped");

  a_member_seen_kept: assert property (@(posedge clk)
    $fell(state_r.member_seen) |-> $past(!rst_n))
    else $error("member_seen cleared outside reset");

endmodule
